// File: rtl/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types and codes of the toy 16-bit processor step core: request and
// response items, memory and register file access groups, opcodes, states.
// ----------------------------------------------------------------------------
package tcpu_pkg;

	// Command field of a request.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] load_address;
		logic [15:0] load_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] next_pc;
		logic        reg_written;
		logic [1:0]  reg_index;
		logic [15:0] reg_value;
		logic        store_done;
		logic [15:0] store_address;
		logic [15:0] store_data;
	} rsp_t;

	typedef enum logic [1:0] {
		STATUS_EXEC    = 2'd0,
		STATUS_HALT    = 2'd1,
		STATUS_ILLEGAL = 2'd2,
		STATUS_LOADED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RUN_ACTIVE = 2'd0,
		RUN_HALTED = 2'd1,
		RUN_ERROR  = 2'd2
	} run_t;

	// Opcodes 14 and 15 are illegal and have no member.
	typedef enum logic [3:0] {
		OP_LDI  = 4'd0,
		OP_ADD  = 4'd1,
		OP_ADDI = 4'd2,
		OP_SUB  = 4'd3,
		OP_XOR  = 4'd4,
		OP_OR   = 4'd5,
		OP_AND  = 4'd6,
		OP_SRA  = 4'd7,
		OP_ORL  = 4'd8,
		OP_ORH  = 4'd9,
		OP_LDM  = 4'd10,
		OP_STM  = 4'd11,
		OP_BLTU = 4'd12,
		OP_BEQ  = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_MEMRD
	} state_t;

	// Word memory access; addresses are full width and wrapped by the memory.
	typedef struct packed {
		logic        we;
		logic [15:0] waddr;
		logic [15:0] wdata;
		logic        re;
		logic [15:0] raddr;
	} mem_req_t;

	// Register file access: one write port, two read ports.
	typedef struct packed {
		logic        we;
		logic [1:0]  waddr;
		logic [15:0] wdata;
		logic        re;
		logic [1:0]  ra_addr;
		logic [1:0]  rb_addr;
	} rf_req_t;

	// Outcome of executing one non-memory-load instruction.
	typedef struct packed {
		logic        wr;
		logic        st;
		logic [15:0] res;
		logic [15:0] npc;
	} exe_t;

	localparam logic [15:0] MSB_MASK = 16'h8000;

endpackage

// File: rtl/tcpu_word_mem.sv
// ----------------------------------------------------------------------------
// tcpu_word_mem
// Unified program and data memory, one write and one registered read port,
// with a clearing pass after reset.
// ----------------------------------------------------------------------------
module tcpu_word_mem import tcpu_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    mem_req,
	output logic [15:0] rdata,
	output logic        clr_busy
);

	localparam int WORDS = 2 ** MEM_ADDR_BITS;

	logic [15:0]              mem [WORDS];
	logic [MEM_ADDR_BITS-1:0] clr_cnt_q;
	logic                     clr_busy_q;
	logic                     wen;
	logic [MEM_ADDR_BITS-1:0] waddr;
	logic [15:0]              wdata;

	assign clr_busy = clr_busy_q;

	// The clearing pass owns the write port until every word is zero.
	always_comb begin
		if (clr_busy_q) begin
			wen   = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else begin
			wen   = mem_req.we;
			waddr = mem_req.waddr[MEM_ADDR_BITS-1:0];
			wdata = mem_req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			rdata <= mem[mem_req.raddr[MEM_ADDR_BITS-1:0]];
		end
	end

endmodule

// File: rtl/tcpu_regfile.sv
// ----------------------------------------------------------------------------
// tcpu_regfile
// Four 16-bit registers, one write and two registered read ports; entries
// not yet written read as zero.
// ----------------------------------------------------------------------------
module tcpu_regfile import tcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rf_req_t     rf_req,
	output logic [15:0] rd_a,
	output logic [15:0] rd_b
);

	logic [15:0] regs [4];
	logic [3:0]  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (rf_req.we) begin
			valid_q[rf_req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_req.we) begin
			regs[rf_req.waddr] <= rf_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_req.re) begin
			rd_a <= valid_q[rf_req.ra_addr] ? regs[rf_req.ra_addr] : '0;
			rd_b <= valid_q[rf_req.rb_addr] ? regs[rf_req.rb_addr] : '0;
		end
	end

endmodule

// File: rtl/tcpu_alu.sv
// ----------------------------------------------------------------------------
// tcpu_alu
// Executes one instruction word against its two operands: register result,
// store request and next program counter.
// ----------------------------------------------------------------------------
module tcpu_alu import tcpu_pkg::*; (
	input  logic [15:0] insn,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic [15:0] pc,
	output exe_t        exe
);

	logic [7:0]  imm;
	logic [15:0] simm;
	logic [15:0] pc_inc;
	logic [15:0] pc_rel;
	op_t         op;

	assign imm    = insn[7:0];
	assign simm   = {{8{imm[7]}}, imm};
	assign pc_inc = pc + 16'd1;
	assign pc_rel = pc + simm;
	assign op     = op_t'(insn[15:12]);

	always_comb begin
		exe.wr  = 1'b1;
		exe.st  = 1'b0;
		exe.res = '0;
		exe.npc = pc_inc;
		case (op)
			OP_LDI:  exe.res = simm;
			OP_ADD:  exe.res = a + b;
			OP_ADDI: exe.res = b + simm;
			OP_SUB:  exe.res = a - b;
			OP_XOR:  exe.res = a ^ b;
			OP_OR:   exe.res = a | b;
			OP_AND:  exe.res = a & b;
			OP_SRA:  exe.res = (a & MSB_MASK) | (a >> 1);
			OP_ORL:  exe.res = a | {8'h00, imm};
			OP_ORH:  exe.res = a | {imm, 8'h00};
			OP_STM: begin
				exe.wr = 1'b0;
				exe.st = 1'b1;
			end
			OP_BLTU: begin
				exe.wr = 1'b0;
				if (a < b) begin
					exe.npc = pc_rel;
				end
			end
			OP_BEQ: begin
				exe.wr = 1'b0;
				if (a == b) begin
					exe.npc = pc_rel;
				end
			end
			default: begin
				// Memory loads finish elsewhere; illegal codes never commit.
				exe.wr = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/toy_16bit_cpu_step_core.sv
// ----------------------------------------------------------------------------
// toy_16bit_cpu_step_core
// Four-register 16-bit toy processor that takes one command per request:
// write a word into memory, or fetch and execute the instruction at pc.
// ----------------------------------------------------------------------------
// A request is accepted into a one-entry buffer whenever that buffer is
// empty, so the next request can be taken while the current one executes and
// while a finished response waits for rsp_ready. Once a request reaches the
// sequencer, a memory write command or a step on a stopped machine is done
// in the idle state; an ordinary step reads pc from the word memory, then
// its operands from the register file, then executes and writes back, and a
// memory load instruction adds a read of its data word, as that needs a
// second pass through the single read port of the word memory. After reset
// the word memory is cleared one word per cycle, and no request is accepted
// until that pass ends. Program and data share the memory, and pc and data
// addresses wrap modulo its size.
// ----------------------------------------------------------------------------
module toy_16bit_cpu_step_core import tcpu_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_item,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_item
);

	localparam logic [15:0] ADDR_MASK = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);

	// Request buffer.
	logic     ibuf_v_q;
	req_t     ibuf_q;
	logic     take;

	// Response register.
	logic     rsp_valid_q;
	rsp_t     rsp_q;
	logic     rsp_load;
	rsp_t     rsp_d;
	logic     out_free;

	// Architectural state outside the two memories.
	logic [15:0] pc_q, pc_d;
	logic [1:0]  zr_q, zr_d, zr_new;
	run_t        run_q, run_d;

	state_t      state_q, state_d;
	logic [15:0] insn_s2;

	mem_req_t    mem_req;
	logic [15:0] mem_rdata;
	logic        clr_busy;
	rf_req_t     rf_req;
	logic [15:0] rf_a, rf_b;
	exe_t        exe;

	tcpu_word_mem #(
		.MEM_ADDR_BITS(MEM_ADDR_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rdata   (mem_rdata),
		.clr_busy(clr_busy)
	);

	tcpu_regfile u_rf (
		.clk   (clk),
		.arst_n(arst_n),
		.rf_req(rf_req),
		.rd_a  (rf_a),
		.rd_b  (rf_b)
	);

	tcpu_alu u_alu (
		.insn(insn_s2),
		.a   (rf_a),
		.b   (rf_b),
		.pc  (pc_q),
		.exe (exe)
	);

	assign req_ready = !ibuf_v_q && !clr_busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// A second all-zero word in a row saturates the run count at two.
	assign zr_new = (insn_s2 == 16'h0000) ? ((zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibuf_v_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			ibuf_v_q <= 1'b1;
		end else if (take) begin
			ibuf_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ibuf_q <= req_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			zr_q    <= '0;
			run_q   <= RUN_ACTIVE;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			zr_q    <= zr_d;
			run_q   <= run_d;
		end
	end

	// The fetched word is kept for the execute and memory load cycles.
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			insn_s2 <= mem_rdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		zr_d     = zr_q;
		run_d    = run_q;
		take     = 1'b0;
		rsp_load = 1'b0;
		rsp_d    = '0;
		mem_req  = '0;
		rf_req   = '0;
		rsp_d.next_pc = pc_q;
		case (state_q)
			S_IDLE: begin
				if (ibuf_v_q) begin
					if (ibuf_q.command == CMD_LOAD) begin
						// Memory writes are taken even when the machine has stopped.
						if (out_free) begin
							mem_req.we    = 1'b1;
							mem_req.waddr = ibuf_q.load_address;
							mem_req.wdata = ibuf_q.load_data;
							rsp_d.status  = STATUS_LOADED;
							rsp_load      = 1'b1;
							take          = 1'b1;
						end
					end else if (run_q != RUN_ACTIVE) begin
						if (out_free) begin
							rsp_d.status = (run_q == RUN_HALTED) ? STATUS_HALT : STATUS_ILLEGAL;
							rsp_load     = 1'b1;
							take         = 1'b1;
						end
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = pc_q;
						take          = 1'b1;
						state_d       = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				rf_req.re      = 1'b1;
				rf_req.ra_addr = mem_rdata[9:8];
				rf_req.rb_addr = mem_rdata[7:6];
				state_d        = S_EXEC;
			end
			S_EXEC: begin
				if (zr_new == 2'd2) begin
					// Halt on the second zero word: pc stays on it.
					if (out_free) begin
						zr_d         = zr_new;
						run_d        = RUN_HALTED;
						rsp_d.status = STATUS_HALT;
						rsp_load     = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (insn_s2[15:13] == 3'b111) begin
					if (out_free) begin
						zr_d         = zr_new;
						run_d        = RUN_ERROR;
						rsp_d.status = STATUS_ILLEGAL;
						rsp_load     = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (op_t'(insn_s2[15:12]) == OP_LDM) begin
					zr_d          = zr_new;
					mem_req.re    = 1'b1;
					mem_req.raddr = rf_b;
					state_d       = S_MEMRD;
				end else if (out_free) begin
					zr_d          = zr_new;
					pc_d          = exe.npc;
					rf_req.we     = exe.wr;
					rf_req.waddr  = insn_s2[9:8];
					rf_req.wdata  = exe.res;
					mem_req.we    = exe.st;
					mem_req.waddr = rf_b;
					mem_req.wdata = rf_a;
					rsp_d.status  = STATUS_EXEC;
					rsp_d.next_pc = exe.npc;
					if (exe.wr) begin
						rsp_d.reg_written = 1'b1;
						rsp_d.reg_index   = insn_s2[9:8];
						rsp_d.reg_value   = exe.res;
					end
					if (exe.st) begin
						rsp_d.store_done    = 1'b1;
						rsp_d.store_address = rf_b & ADDR_MASK;
						rsp_d.store_data    = rf_a;
					end
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_MEMRD: begin
				// The data word sits in the read register until the response fits.
				if (out_free) begin
					pc_d              = pc_q + 16'd1;
					rf_req.we         = 1'b1;
					rf_req.waddr      = insn_s2[9:8];
					rf_req.wdata      = mem_rdata;
					rsp_d.status      = STATUS_EXEC;
					rsp_d.next_pc     = pc_q + 16'd1;
					rsp_d.reg_written = 1'b1;
					rsp_d.reg_index   = insn_s2[9:8];
					rsp_d.reg_value   = mem_rdata;
					rsp_load          = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The sequencer never reads and writes the word memory in one cycle.
	a_mem_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("word memory read and write issued together");

	// Register file reads and writes come from different sequencer states.
	a_rf_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_req.we && rf_req.re))
		else $error("register file read and write issued together");

	// A stopped machine keeps its program counter.
	a_stop_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q != RUN_ACTIVE) |=> $stable(pc_q))
		else $error("program counter moved after a stop");

	// No request enters while the memory is being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req_ready)
		else $error("request accepted during the clearing pass");

endmodule
